FILE: hw/rtl/synth_voice_allocator_macros.svh
// assertion macros for the voice allocator checker
// no dependencies
`ifndef SYNTH_VOICE_ALLOCATOR_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_MACROS_SVH
// property checked on every rising clock edge outside reset
`define SVA_CHECK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed");
`define SVA_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) else $error("check failed");
`endif

FILE: hw/rtl/sva_pkg.sv
// shared types and constants for the voice allocator
// no dependencies
package sva_pkg;
   localparam int NUM_VOICES = 8;
   localparam int HELD_DEPTH = 16;
   localparam int VW = 4;
   localparam int HCW = 5;

   localparam logic [2:0] ACT_NOTE_ON = 3'd0;
   localparam logic [2:0] ACT_NOTE_OFF = 3'd1;
   localparam logic [2:0] ACT_VOICE_ENDED = 3'd2;
   localparam logic [2:0] ACT_TICK = 3'd3;
   localparam logic [2:0] ACT_ALL_NOTES_OFF = 3'd4;
   localparam logic [2:0] ACT_ALL_SOUND_OFF = 3'd5;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STEAL = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;
   localparam logic [1:0] CMD_STOP = 2'd3;

   typedef struct packed {
      logic [2:0] action;
      logic [6:0] note;
      logic [6:0] velocity;
      logic [3:0] voice_index;
   } req_type;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] voice;
      logic [6:0] note_out;
      logic [6:0] velocity_out;
      logic       last;
   } rsp_type;

   // broadcast to every voice cell
   typedef struct packed {
      logic       tick;
      logic       kill_all;
      logic       clear_notes;
      logic       end_one;
      logic [3:0] end_idx;
      logic       start_one;
      logic [3:0] start_idx;
      logic [6:0] start_note;
      logic       clr_one;
      logic [3:0] clr_idx;
   } vctl_type;

   // one voice as seen by the scan chain
   typedef struct packed {
      logic        active;
      logic [31:0] age;
      logic        has_note;
      logic [6:0]  note;
   } vstat_type;

   // scan word handed along the voice cells
   typedef struct packed {
      logic        found_idle;
      logic [3:0]  idle_idx;
      logic        any;
      logic [3:0]  old_idx;
      logic [31:0] old_age;
      logic        hit;
      logic [3:0]  hit_idx;
      logic        hit_active;
   } scan_type;

   typedef struct packed {
      logic       clear;
      logic       shift;
      logic [4:0] shift_pos;
      logic       push;
      logic [4:0] push_pos;
      logic [6:0] note;
      logic [6:0] vel;
   } hctl_type;
endpackage

FILE: hw/rtl/sva_voice_cell.sv
// one voice cell: active flag, age and note, plus one stage of the scan chain
// depends on sva_pkg
module sva_voice_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic [3:0]          my_idx,
   input  sva_pkg::vctl_type   ctl,
   input  logic [6:0]          match_note,
   input  sva_pkg::scan_type   scan_i,
   output sva_pkg::scan_type   scan_o,
   output sva_pkg::vstat_type  stat
);
   import sva_pkg::*;
   logic        active_ff, active_in;
   logic [31:0] age_ff, age_in;
   logic        hasn_ff, hasn_in;
   logic [6:0]  note_ff, note_in;

   always_comb begin
      active_in = active_ff;
      age_in = age_ff;
      hasn_in = hasn_ff;
      note_in = note_ff;
      if (ctl.tick && active_ff && age_ff != 32'hFFFF_FFFF) age_in = age_ff + 32'd1;
      if (ctl.clear_notes) hasn_in = 1'b0;
      if (ctl.kill_all) active_in = 1'b0;
      if (ctl.clr_one && ctl.clr_idx == my_idx) hasn_in = 1'b0;
      if (ctl.end_one && ctl.end_idx == my_idx) begin
         active_in = 1'b0;
         hasn_in = 1'b0;
      end
      if (ctl.start_one && ctl.start_idx == my_idx) begin
         active_in = 1'b1;
         age_in = '0;
         hasn_in = 1'b1;
         note_in = ctl.start_note;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         age_ff <= '0;
         hasn_ff <= 1'b0;
         note_ff <= '0;
      end else begin
         active_ff <= active_in;
         age_ff <= age_in;
         hasn_ff <= hasn_in;
         note_ff <= note_in;
      end
   end

   // scan stage: first idle voice, oldest active voice (lower index on a tie), highest-indexed voice with the note
   always_comb begin
      scan_o = scan_i;
      if (!scan_i.found_idle && !active_ff) begin
         scan_o.found_idle = 1'b1;
         scan_o.idle_idx = my_idx;
      end
      if (active_ff && (!scan_i.any || age_ff > scan_i.old_age)) begin
         scan_o.any = 1'b1;
         scan_o.old_idx = my_idx;
         scan_o.old_age = age_ff;
      end
      if (hasn_ff && note_ff == match_note) begin
         scan_o.hit = 1'b1;
         scan_o.hit_idx = my_idx;
         scan_o.hit_active = active_ff;
      end
   end

   assign stat.active = active_ff;
   assign stat.age = age_ff;
   assign stat.has_note = hasn_ff;
   assign stat.note = note_ff;
endmodule

FILE: hw/rtl/sva_held_cell.sv
// one entry of the held-note stack with its velocity
// depends on sva_pkg
module sva_held_cell (
   input  logic              clock,
   input  logic [4:0]        my_pos,
   input  sva_pkg::hctl_type ctl,
   input  logic [6:0]        next_note,
   input  logic [6:0]        next_vel,
   output logic [6:0]        note,
   output logic [6:0]        vel
);
   import sva_pkg::*;
   logic [6:0] note_ff, note_in, vel_ff, vel_in;

   always_comb begin
      note_in = note_ff;
      vel_in = vel_ff;
      if (ctl.shift && my_pos >= ctl.shift_pos) begin
         note_in = next_note;
         vel_in = next_vel;
      end
      if (ctl.push && my_pos == ctl.push_pos) begin
         note_in = ctl.note;
         vel_in = ctl.vel;
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
      vel_ff <= vel_in;
   end

   assign note = note_ff;
   assign vel = vel_ff;
endmodule

FILE: hw/rtl/synth_voice_allocator.sv
// voice allocator top level: sequencer, voice cell chain and held stack
// depends on sva_pkg, sva_voice_cell, sva_held_cell
//
// channel  dir  handshake          word
// req      in   req_valid/stall    action, note, velocity, voice_index
// rsp      out  rsp_valid/stall    command, voice, note_out, velocity_out, last
// csr      in   csr_write          mono_mode
//
// all-off events walk NUM_VOICES voices, one command per cycle while rsp is not
// stalled. the held stack search is a compare across its cells. reset is
// synchronous and clears every voice.
// rsp_stall holds the sequencer; req is taken only when it is idle.
module synth_voice_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sva_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sva_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_data
);
   import sva_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_EMIT = 3'd2;
   localparam logic [2:0] ST_EMIT2 = 3'd3;
   localparam logic [2:0] ST_SWEEP = 3'd4;

   logic [2:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   logic        mono_ff, mono_in;
   logic [HCW-1:0] cnt_ff, cnt_in;
   logic [3:0]  sweep_ff, sweep_in;
   logic        ovalid_ff, ovalid_in;
   rsp_type     odata_ff, odata_in;
   rsp_type     pend_ff, pend_in;
   rsp_type     next_ff, next_in;

   vctl_type  vctl;
   hctl_type  hctl;
   scan_type  chain [NUM_VOICES+1];
   vstat_type vst [NUM_VOICES];
   logic [6:0] hn [HELD_DEPTH+1];
   logic [6:0] hv [HELD_DEPTH+1];

   // mono voice 0 mapping is held in its cell; tracked note for note-off
   assign chain[0] = '0;

   for (genvar g = 0; g < NUM_VOICES; g++) begin : g_voice
      sva_voice_cell u_cell (
         .clock, .reset, .my_idx(4'(g)), .ctl(vctl), .match_note(req_ff.note),
         .scan_i(chain[g]), .scan_o(chain[g+1]), .stat(vst[g]));
   end

   assign hn[HELD_DEPTH] = '0;
   assign hv[HELD_DEPTH] = '0;
   for (genvar g = 0; g < HELD_DEPTH; g++) begin : g_held
      sva_held_cell u_held (
         .clock, .my_pos(5'(g)), .ctl(hctl), .next_note(hn[g+1]),
         .next_vel(hv[g+1]), .note(hn[g]), .vel(hv[g]));
   end

   // held stack search
   logic           hfound;
   logic [HCW-1:0] hpos;
   always_comb begin
      hfound = 1'b0;
      hpos = '0;
      for (int i = HELD_DEPTH - 1; i >= 0; i--) begin
         if (HCW'(i) < cnt_ff && hn[i] == req_ff.note) begin
            hfound = 1'b1;
            hpos = HCW'(i);
         end
      end
   end

   scan_type sc;
   assign sc = chain[NUM_VOICES];
   logic [3:0] pick;
   assign pick = sc.found_idle ? sc.idle_idx : sc.old_idx;
   logic pick_active;
   assign pick_active = !sc.found_idle;
   logic [HCW-1:0] cnt_m1;
   assign cnt_m1 = cnt_ff - HCW'(1);
   logic [3:0] cntm1_idx;
   assign cntm1_idx = cnt_m1[3:0];
   logic out_free;
   assign out_free = !ovalid_ff || !rsp_stall;

   function automatic rsp_type mk(input logic [1:0] c, input logic [3:0] v,
                                  input logic [6:0] n, input logic [6:0] vl,
                                  input logic l);
      rsp_type r;
      r.command = c; r.voice = v; r.note_out = n; r.velocity_out = vl; r.last = l;
      return r;
   endfunction

   always_comb begin
      logic [HCW-1:0] c2;
      logic [3:0] top;
      state_in = state_ff;
      req_in = req_ff;
      mono_in = mono_ff;
      cnt_in = cnt_ff;
      sweep_in = sweep_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      odata_in = odata_ff;
      pend_in = pend_ff;
      next_in = next_ff;
      vctl = '0;
      hctl = '0;
      c2 = cnt_ff;
      top = '0;
      if (csr_write && csr_data != mono_ff) begin
         mono_in = csr_data;
         cnt_in = '0;
         vctl.clear_notes = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            case (req_ff.action)
               ACT_NOTE_ON: begin
                  if (mono_ff) begin
                     if (hfound) begin
                        hctl.shift = 1'b1;
                        hctl.shift_pos = hpos;
                        c2 = cnt_m1;
                     end else if (cnt_ff >= HCW'(HELD_DEPTH)) begin
                        hctl.shift = 1'b1;
                        hctl.shift_pos = '0;
                        c2 = cnt_m1;
                     end
                     hctl.push = 1'b1;
                     hctl.push_pos = c2;
                     hctl.note = req_ff.note;
                     hctl.vel = req_ff.velocity;
                     cnt_in = c2 + HCW'(1);
                     vctl.clear_notes = 1'b1;
                     vctl.start_one = 1'b1;
                     vctl.start_idx = '0;
                     vctl.start_note = req_ff.note;
                     pend_in = mk(CMD_START, '0, req_ff.note, req_ff.velocity, 1'b1);
                     state_in = ST_EMIT2;
                  end else begin
                     if (sc.hit && sc.hit_idx != pick && sc.hit_active) begin
                        vctl.clr_one = 1'b1;
                        vctl.clr_idx = sc.hit_idx;
                        pend_in = mk(CMD_RELEASE, sc.hit_idx, '0, '0, 1'b0);
                        next_in = mk(pick_active ? CMD_STEAL : CMD_START, pick,
                                     req_ff.note, req_ff.velocity, 1'b1);
                        state_in = ST_EMIT;
                     end else begin
                        pend_in = mk(pick_active ? CMD_STEAL : CMD_START, pick,
                                     req_ff.note, req_ff.velocity, 1'b1);
                        state_in = ST_EMIT2;
                     end
                     vctl.start_one = 1'b1;
                     vctl.start_idx = pick;
                     vctl.start_note = req_ff.note;
                  end
               end
               ACT_NOTE_OFF: begin
                  if (mono_ff) begin
                     if (hfound) begin
                        hctl.shift = 1'b1;
                        hctl.shift_pos = hpos;
                        cnt_in = cnt_m1;
                        if (cnt_m1 == '0) begin
                           vctl.clear_notes = 1'b1;
                           pend_in = mk(CMD_RELEASE, '0, '0, '0, 1'b1);
                           state_in = ST_EMIT2;
                        end else if (vst[0].has_note && vst[0].note == req_ff.note) begin
                           // newest remaining entry sits at count-1 after removal
                           top = (hpos == cnt_m1) ? cnt_m1[3:0] - 4'd1 : cntm1_idx;
                           vctl.clear_notes = 1'b1;
                           vctl.start_one = 1'b1;
                           vctl.start_idx = '0;
                           vctl.start_note = hn[top];
                           pend_in = mk(CMD_START, '0, hn[top], hv[top], 1'b1);
                           if (hpos != cnt_m1) begin
                              top = cntm1_idx;
                              vctl.start_note = hn[top];
                              pend_in = mk(CMD_START, '0, hn[top], hv[top], 1'b1);
                           end
                           state_in = ST_EMIT2;
                        end
                     end
                  end else if (sc.hit) begin
                     vctl.clr_one = 1'b1;
                     vctl.clr_idx = sc.hit_idx;
                     pend_in = mk(CMD_RELEASE, sc.hit_idx, '0, '0, 1'b1);
                     state_in = ST_EMIT2;
                  end
               end
               ACT_VOICE_ENDED: begin
                  if (32'(req_ff.voice_index) < NUM_VOICES) begin
                     vctl.end_one = 1'b1;
                     vctl.end_idx = req_ff.voice_index;
                  end
               end
               ACT_TICK: vctl.tick = 1'b1;
               ACT_ALL_NOTES_OFF, ACT_ALL_SOUND_OFF: begin
                  cnt_in = '0;
                  vctl.clear_notes = 1'b1;
                  if (req_ff.action == ACT_ALL_SOUND_OFF) vctl.kill_all = 1'b1;
                  sweep_in = '0;
                  state_in = ST_SWEEP;
               end
               default: ;
            endcase
         end
         ST_EMIT: begin
            if (out_free) begin
               odata_in = pend_ff;
               ovalid_in = 1'b1;
               pend_in = next_ff;
               state_in = ST_EMIT2;
            end
         end
         ST_EMIT2: begin
            if (out_free) begin
               odata_in = pend_ff;
               ovalid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (out_free) begin
               odata_in = mk(req_ff.action == ACT_ALL_NOTES_OFF ? CMD_RELEASE : CMD_STOP,
                             sweep_ff, '0, '0,
                             32'(sweep_ff) == NUM_VOICES - 1);
               ovalid_in = 1'b1;
               sweep_in = sweep_ff + 4'd1;
               if (32'(sweep_ff) == NUM_VOICES - 1) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mono_ff <= 1'b0;
         cnt_ff <= '0;
         sweep_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mono_ff <= mono_in;
         cnt_ff <= cnt_in;
         sweep_ff <= sweep_in;
         ovalid_ff <= ovalid_in;
      end
      req_ff <= req_in;
      odata_ff <= odata_in;
      pend_ff <= pend_in;
      next_ff <= next_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_data = odata_ff;
endmodule

FILE: hw/rtl/sva_checker.sv
// port-level checks for the voice allocator, bound to the top level
// depends on sva_pkg and synth_voice_allocator_macros.svh
`include "synth_voice_allocator_macros.svh"
module sva_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sva_pkg::rsp_type rsp_data
);
   import sva_pkg::*;
   logic quiet_cmd;
   logic zero_payload;
   assign quiet_cmd = rsp_valid &&
                      (rsp_data.command == CMD_RELEASE || rsp_data.command == CMD_STOP);
   assign zero_payload = rsp_data.note_out == '0 && rsp_data.velocity_out == '0;

   `SVA_CHECK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `SVA_CHECK(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall)
   `SVA_CHECK(a_no_start_note_zero_rel, clock, reset, quiet_cmd |-> zero_payload)
   `SVA_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_stall)
endmodule

bind synth_voice_allocator sva_checker u_sva_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data);

FILE: tb/tb_synth_voice_allocator.sv
// self-checking bench for synth_voice_allocator: random and directed events, scoreboard
// depends on sva_pkg and synth_voice_allocator
module tb_synth_voice_allocator;
   import sva_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   // voice allocation state, mirrored on the bench side
   class voice_scoreboard;
      bit          mono;
      bit          active [NUM_VOICES];
      bit [31:0]   age [NUM_VOICES];
      bit [7:0]    vnote [NUM_VOICES];
      bit [4:0]    map [128];
      bit [6:0]    hnote [HELD_DEPTH];
      bit [6:0]    hvel [HELD_DEPTH];
      int          hcount;
      rsp_type     pending [$];
      int          errors;
      int          checked;

      function void clear_maps();
         foreach (vnote[i]) vnote[i] = 8'd255;
         foreach (map[i]) map[i] = 5'd31;
      endfunction

      function void reset_state();
         mono = 0;
         foreach (active[i]) begin
            active[i] = 0;
            age[i] = 0;
         end
         hcount = 0;
         clear_maps();
      endfunction

      function void set_mode(bit m);
         if (m != mono) begin
            mono = m;
            hcount = 0;
            clear_maps();
         end
      endfunction

      function void push(logic [1:0] cmd, int v, int n, int vel);
         rsp_type r;
         r.command = cmd;
         r.voice = v[3:0];
         r.note_out = n[6:0];
         r.velocity_out = vel[6:0];
         r.last = 0;
         pending.push_back(r);
      endfunction

      function void unmap_voice(int v);
         int n;
         n = vnote[v];
         if (n < 128 && map[n] == v) map[n] = 5'd31;
         vnote[v] = 8'd255;
      endfunction

      function void begin_voice(int v, int n);
         active[v] = 1;
         age[v] = 0;
         vnote[v] = n[7:0];
         map[n] = v[4:0];
      endfunction

      function int held_find(int n);
         for (int i = 0; i < hcount; i++)
            if (hnote[i] == n) return i;
         return -1;
      endfunction

      function void held_drop(int pos);
         for (int j = pos; j + 1 < hcount; j++) begin
            hnote[j] = hnote[j + 1];
            hvel[j] = hvel[j + 1];
         end
         hcount--;
      endfunction

      function void mono_start(int n, int vel);
         clear_maps();
         begin_voice(0, n);
         push(CMD_START, 0, n, vel);
      endfunction

      // note an accepted word and queue the commands it should cause
      function void note_request(req_type q);
         int n, vel, vi, pos, idx, ex, first;
         bit [31:0] best;
         n = q.note;
         vel = q.velocity;
         vi = q.voice_index;
         first = pending.size();
         case (q.action)
            ACT_NOTE_ON: begin
               if (mono) begin
                  pos = held_find(n);
                  if (pos >= 0) held_drop(pos);
                  if (hcount >= HELD_DEPTH) held_drop(0);
                  hnote[hcount] = n[6:0];
                  hvel[hcount] = vel[6:0];
                  hcount++;
                  mono_start(n, vel);
               end else begin
                  idx = -1;
                  best = 0;
                  for (int i = 0; i < NUM_VOICES; i++) begin
                     if (!active[i]) begin
                        idx = i;
                        break;
                     end
                  end
                  if (idx < 0) begin
                     idx = 0;
                     best = age[0];
                     for (int i = 1; i < NUM_VOICES; i++)
                        if (age[i] > best) begin
                           idx = i;
                           best = age[i];
                        end
                  end
                  ex = map[n];
                  if (ex < NUM_VOICES && ex != idx && active[ex]) begin
                     push(CMD_RELEASE, ex, 0, 0);
                     unmap_voice(ex);
                  end
                  unmap_voice(idx);
                  push(active[idx] ? CMD_STEAL : CMD_START, idx, n, vel);
                  begin_voice(idx, n);
               end
            end
            ACT_NOTE_OFF: begin
               if (mono) begin
                  pos = held_find(n);
                  if (pos >= 0) begin
                     held_drop(pos);
                     if (hcount == 0) begin
                        clear_maps();
                        push(CMD_RELEASE, 0, 0, 0);
                     end else if (vnote[0] == n) begin
                        mono_start(hnote[hcount - 1], hvel[hcount - 1]);
                     end
                  end
               end else begin
                  idx = map[n];
                  if (idx < NUM_VOICES) begin
                     push(CMD_RELEASE, idx, 0, 0);
                     unmap_voice(idx);
                  end
               end
            end
            ACT_VOICE_ENDED: begin
               if (vi < NUM_VOICES) begin
                  active[vi] = 0;
                  unmap_voice(vi);
               end
            end
            ACT_TICK: begin
               foreach (active[i])
                  if (active[i] && age[i] != 32'hFFFF_FFFF) age[i]++;
            end
            ACT_ALL_NOTES_OFF, ACT_ALL_SOUND_OFF: begin
               hcount = 0;
               clear_maps();
               for (int i = 0; i < NUM_VOICES; i++) begin
                  push(q.action == ACT_ALL_NOTES_OFF ? CMD_RELEASE : CMD_STOP, i, 0, 0);
                  if (q.action == ACT_ALL_SOUND_OFF) active[i] = 0;
               end
            end
            default: ;
         endcase
         if (pending.size() > first) pending[pending.size() - 1].last = 1;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            $error("unexpected command word %p", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.command !== want.command) begin
            $error("command: expected %0d, got %0d", want.command, got.command);
            errors++;
         end
         if (got.voice !== want.voice) begin
            $error("voice: expected %0d, got %0d", want.voice, got.voice);
            errors++;
         end
         if (got.note_out !== want.note_out) begin
            $error("note_out: expected %0d, got %0d", want.note_out, got.note_out);
            errors++;
         end
         if (got.velocity_out !== want.velocity_out) begin
            $error("velocity_out: expected %0d, got %0d", want.velocity_out,
                   got.velocity_out);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   logic    csr_write = 0;
   logic    csr_data = 0;

   voice_scoreboard sb;
   bit      calm = 0;
   bit      hold_rsp = 0;
   int      idle_cycles = 0;
   int      events_sent = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   synth_voice_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   // sample on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver stall, random except in calm stretches or a forced hold
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1;
      else if (calm) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(99) < 11);
   end

   // valid stays up between words unless an idle cycle is taken
   task automatic send_event(req_type q);
      if (!calm)
         while ($urandom_range(99) < 11) begin
            req_valid <= 0;
            @(negedge clock);
         end
      req_data <= q;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note_request(q);
      events_sent++;
      @(negedge clock);
   endtask

   task automatic send(logic [2:0] act, int n, int vel, int vi);
      req_type q;
      q.action = act;
      q.note = n[6:0];
      q.velocity = vel[6:0];
      q.voice_index = vi[3:0];
      send_event(q);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_mode(bit m);
      drain();
      csr_data <= m;
      csr_write <= 1;
      @(negedge clock);
      sb.set_mode(m);
      csr_write <= 0;
      csr_data <= 0;
   endtask

   // mostly note traffic on a small note pool so voices and the stack collide
   task automatic random_events(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 45)
            send(ACT_NOTE_ON, $urandom_range(1) ? $urandom_range(60, 71) :
                 $urandom_range(127), $urandom_range(127), 0);
         else if (r < 75)
            send(ACT_NOTE_OFF, $urandom_range(1) ? $urandom_range(60, 71) :
                 $urandom_range(127), $urandom_range(127), $urandom_range(15));
         else if (r < 85)
            send(ACT_TICK, $urandom_range(127), 0, 0);
         else if (r < 93)
            send(ACT_VOICE_ENDED, 0, 0, $urandom_range(15));
         else if (r < 96)
            send(ACT_ALL_NOTES_OFF, 0, 0, 0);
         else if (r < 98)
            send(ACT_ALL_SOUND_OFF, $urandom_range(127), $urandom_range(127), 0);
         else
            send(3'($urandom_range(6, 7)), $urandom_range(127), $urandom_range(127),
                 $urandom_range(15));
      end
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed poly: fill, steal oldest, same note twice, off of unknown note
      for (int v = 0; v < NUM_VOICES; v++) begin
         send(ACT_NOTE_ON, v == 0 ? 0 : 120 + v, v == 0 ? 127 : v, 0);
         send(ACT_TICK, 0, 0, 0);
      end
      send(ACT_NOTE_ON, 127, 0, 0);
      send(ACT_NOTE_ON, 127, 64, 0);
      send(ACT_NOTE_OFF, 55, 0, 0);
      send(ACT_NOTE_OFF, 127, 0, 0);
      send(ACT_VOICE_ENDED, 0, 0, 15);
      send(ACT_VOICE_ENDED, 0, 0, 3);
      send(ACT_ALL_NOTES_OFF, 0, 0, 0);
      send(ACT_ALL_SOUND_OFF, 0, 0, 0);
      send(3'd7, 127, 127, 15);

      // directed mono: legato, retrigger, stack overflow
      write_mode(1);
      send(ACT_NOTE_ON, 60, 100, 0);
      send(ACT_NOTE_ON, 64, 90, 0);
      send(ACT_NOTE_OFF, 60, 0, 0);
      send(ACT_NOTE_OFF, 64, 0, 0);
      send(ACT_NOTE_OFF, 99, 0, 0);
      for (int k = 0; k < HELD_DEPTH + 2; k++) send(ACT_NOTE_ON, 40 + k, k, 0);
      send(ACT_NOTE_OFF, 40 + HELD_DEPTH + 1, 0, 0);
      write_mode(1);
      send(ACT_ALL_NOTES_OFF, 0, 0, 0);

      // long hold on the receiver so the block backs up
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         random_events(20);
      join
      write_mode(0);
      random_events(140);
      calm = 1;
      random_events(60);
      calm = 0;
      write_mode(1);
      random_events(120);
      write_mode(0);
      random_events(60);
      drain();

      $display("%0d events sent, %0d commands checked across poly and mono modes",
               events_sent, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
